// ===== rtl/mor_pkg.sv =====
// ----------------------------------------------------------------------------
// mor_pkg
// Shared types and constants of the MIPS overlay relocator.
// ----------------------------------------------------------------------------
`default_nettype none

package mor_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH = 3'd3;

  localparam logic [5:0] RT_MIPS_32   = 6'd2;
  localparam logic [5:0] RT_MIPS_26   = 6'd4;
  localparam logic [5:0] RT_MIPS_HI16 = 6'd5;
  localparam logic [5:0] RT_MIPS_LO16 = 6'd6;

  localparam logic [1:0] SEC_ABS  = 2'd0;
  localparam logic [1:0] SEC_TEXT = 2'd1;
  localparam logic [1:0] SEC_DATA = 2'd2;

  localparam logic [31:0] ADDR_CHECK_MASK = 32'h0F00_0000;
  localparam logic [31:0] KSEG0_TOP       = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] reloc_word;
    logic [31:0] target_word;
    logic        table_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [31:0] write_value;
    logic        last_write;
  } out_item_t;

  typedef struct packed {
    logic [31:0] load_base;
    logic [31:0] link_base;
    logic [23:0] text_length;
    logic [23:0] data_length;
    logic [31:0] delta;
  } cfg_t;

  // HI16 pairing slot: target address, low half of the original LUI word,
  // and the current LUI word
  typedef struct packed {
    logic [31:0] address;
    logic [15:0] orig_lo;
    logic [31:0] current;
  } pair_entry_t;

  typedef struct packed {
    logic [1:0]  count;
    out_item_t   first;
    out_item_t   second;
  } patch_res_t;

endpackage

`default_nettype wire

// ===== rtl/mips_overlay_relocator.sv =====
// ----------------------------------------------------------------------------
// mips_overlay_relocator
// Patches 32-bit, jump, HI16 and LO16 relocations of an overlay for its load base.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready as one relocation word, the word now at
// its target and a table-end flag. Each request yields zero, one or two memory
// writes on out_valid/out_ready, the last flagged by last_write; LO16 gives the
// LUI write first, then the low word. HI16 only fills the pairing table.
// Registers are written on cfg_valid/cfg_ready (always ready) while idle; the
// user must keep to this, the block does not enforce it. An accepted request
// is registered in the processing stage as the pairing table is read; its
// writes pass through the output stage to out_*. With no stall, a single-write
// request is taken every cycle; a LO16 request holds the output stage until
// both writes leave the single output port. The table is one read/one write
// memory, read-modify-write with forwarding between back-to-back requests on
// the same slot. Reset clears the registers, the output stage and all pairing
// valid bits; table data is not cleared. When the receiver stalls, the output
// stage fills, then the processing stage holds and in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_overlay_relocator #(
  parameter int unsigned PAIR_ENTRIES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire mor_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output mor_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mor_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  localparam int unsigned IDX_W = $clog2(PAIR_ENTRIES);

  mor_pkg::cfg_t        cfg;
  mor_pkg::in_item_t    s1_item_r;
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic                 s1_retire;
  logic                 in_fire;
  logic                 ob_space;
  mor_pkg::pair_entry_t rd_entry;
  logic                 rd_valid;
  mor_pkg::patch_res_t  res;
  logic                 p_wr_en;
  logic [IDX_W-1:0]     p_wr_idx;
  mor_pkg::pair_entry_t p_wr_entry;

  mor_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s1_retire = s1_valid_r && ob_space;
  assign in_ready  = !s1_valid_r || s1_retire;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_retire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
  end

  mor_pair_mem #(.PAIR_ENTRIES(PAIR_ENTRIES)) u_pair_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_idx   (in_data.target_word[21 +: IDX_W]),
    .wr_en    (p_wr_en && s1_retire),
    .wr_idx   (p_wr_idx),
    .wr_entry (p_wr_entry),
    .clr_all  (s1_retire && s1_item_r.table_end),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  mor_patch #(.PAIR_ENTRIES(PAIR_ENTRIES)) u_patch (
    .cfg         (cfg),
    .item        (s1_item_r),
    .entry       (rd_entry),
    .entry_valid (rd_valid),
    .res         (res),
    .wr_en       (p_wr_en),
    .wr_idx      (p_wr_idx),
    .wr_entry    (p_wr_entry)
  );

  mor_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_retire && (res.count != 2'd0)),
    .push_res  (res),
    .space     (ob_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_retire) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("processing stage lost or changed a held request");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !ob_space) |-> !in_fire)
    else $error("request accepted while processing stage blocked");

  a_clear_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_retire && s1_item_r.table_end) |=> (u_pair_mem.valid_r == '0))
    else $error("pairing table not cleared after table end");
`endif

endmodule

`default_nettype wire

// ===== rtl/mor_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mor_cfg_regs
// Configuration registers; keeps load_base - link_base ready for use.
// ----------------------------------------------------------------------------
`default_nettype none

module mor_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mor_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data,
  output mor_pkg::cfg_t                      cfg
);

  mor_pkg::cfg_t cfg_r;
  mor_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        mor_pkg::CFG_LOAD_BASE: begin
          cfg_nxt.load_base = cfg_data;
          cfg_nxt.delta     = cfg_data - cfg_r.link_base;
        end
        mor_pkg::CFG_LINK_BASE: begin
          cfg_nxt.link_base = cfg_data;
          cfg_nxt.delta     = cfg_r.load_base - cfg_data;
        end
        mor_pkg::CFG_TEXT_LENGTH: cfg_nxt.text_length = cfg_data[23:0];
        mor_pkg::CFG_DATA_LENGTH: cfg_nxt.data_length = cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mor_pair_mem.sv =====
// ----------------------------------------------------------------------------
// mor_pair_mem
// HI16 pairing table: synchronous memory with write forwarding, valid flops.
// ----------------------------------------------------------------------------
`default_nettype none

module mor_pair_mem #(
  parameter int unsigned PAIR_ENTRIES = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(PAIR_ENTRIES)-1:0]   rd_idx,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(PAIR_ENTRIES)-1:0]   wr_idx,
  input  wire mor_pkg::pair_entry_t              wr_entry,
  input  wire logic                              clr_all,
  output mor_pkg::pair_entry_t                   rd_entry,
  output logic                                   rd_valid
);

  localparam int unsigned IDX_W = $clog2(PAIR_ENTRIES);

  mor_pkg::pair_entry_t pair_mem [PAIR_ENTRIES];

  mor_pkg::pair_entry_t mem_q_r;
  mor_pkg::pair_entry_t fwd_entry_r;
  logic                 fwd_hit_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [PAIR_ENTRIES-1:0] valid_r;
  logic [PAIR_ENTRIES-1:0] valid_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pair_mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      mem_q_r <= pair_mem[rd_idx];
    end
  end

  // a write landing on the same edge as the read is taken from the bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_entry_r <= wr_entry;
      rd_idx_r    <= rd_idx;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_idx] = 1'b1;
    end
    if (clr_all) begin
      valid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign rd_entry = fwd_hit_r ? fwd_entry_r : mem_q_r;
  assign rd_valid = valid_r[rd_idx_r];

endmodule

`default_nettype wire

// ===== rtl/mor_patch.sv =====
// ----------------------------------------------------------------------------
// mor_patch
// Target address, relocation arithmetic and table update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module mor_patch #(
  parameter int unsigned PAIR_ENTRIES = 32
) (
  input  wire mor_pkg::cfg_t                   cfg,
  input  wire mor_pkg::in_item_t               item,
  input  wire mor_pkg::pair_entry_t            entry,
  input  wire logic                            entry_valid,
  output mor_pkg::patch_res_t                  res,
  output logic                                 wr_en,
  output logic [$clog2(PAIR_ENTRIES)-1:0]      wr_idx,
  output mor_pkg::pair_entry_t                 wr_entry
);

  localparam int unsigned IDX_W = $clog2(PAIR_ENTRIES);

  logic [31:0] rw;
  logic [31:0] tw;
  logic [5:0]  rtype;
  logic [31:0] text_end;
  logic [31:0] base;
  logic [31:0] addr;
  logic [31:0] lo_ext;
  logic [31:0] check;
  logic [31:0] rel_lo;
  logic [15:0] hi;
  logic [31:0] lui;
  logic [31:0] jmp_rel;
  logic [31:0] abs_rel;

  always_comb begin
    rw       = item.reloc_word;
    tw       = item.target_word;
    rtype    = rw[29:24];
    text_end = cfg.load_base + {8'd0, cfg.text_length};
    case (rw[31:30])
      mor_pkg::SEC_ABS:  base = '0;
      mor_pkg::SEC_TEXT: base = cfg.load_base;
      mor_pkg::SEC_DATA: base = text_end;
      default:           base = text_end + {8'd0, cfg.data_length};
    endcase
    addr    = base + {8'd0, rw[23:0]};
    lo_ext  = {{16{tw[15]}}, tw[15:0]};
    check   = {entry.current[15:0], 16'd0} + lo_ext;
    rel_lo  = {entry.orig_lo, 16'd0} + lo_ext + cfg.delta;
    hi      = rel_lo[31:16] + {15'd0, rel_lo[15]};
    lui     = {entry.current[31:16], hi};
    jmp_rel = (mor_pkg::KSEG0_TOP | {4'd0, tw[25:0], 2'd0}) + cfg.delta;
    abs_rel = tw + cfg.delta;
  end

  always_comb begin
    res      = '0;
    wr_en    = 1'b0;
    wr_idx   = tw[21 +: IDX_W];
    wr_entry = entry;
    unique case (rtype)
      mor_pkg::RT_MIPS_32: begin
        if ((tw & mor_pkg::ADDR_CHECK_MASK) == '0) begin
          res.count = 2'd1;
          res.first = '{write_address: addr, write_value: abs_rel, last_write: 1'b1};
        end
      end
      mor_pkg::RT_MIPS_26: begin
        res.count = 2'd1;
        res.first = '{write_address: addr, write_value: {tw[31:26], jmp_rel[27:2]},
                      last_write: 1'b1};
      end
      mor_pkg::RT_MIPS_HI16: begin
        wr_en    = 1'b1;
        wr_idx   = tw[16 +: IDX_W];
        wr_entry = '{address: addr, orig_lo: tw[15:0], current: tw};
      end
      mor_pkg::RT_MIPS_LO16: begin
        if (entry_valid && ((check & mor_pkg::ADDR_CHECK_MASK) == '0)) begin
          wr_en            = 1'b1;
          wr_entry.current = lui;
          res.count        = 2'd2;
          res.first  = '{write_address: entry.address, write_value: lui, last_write: 1'b0};
          res.second = '{write_address: addr, write_value: {tw[31:16], rel_lo[15:0]},
                         last_write: 1'b1};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mor_out_buf.sv =====
// ----------------------------------------------------------------------------
// mor_out_buf
// Two-entry output stage; takes all writes of one request at once.
// ----------------------------------------------------------------------------
`default_nettype none

module mor_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire mor_pkg::patch_res_t  push_res,
  output logic                      space,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mor_pkg::out_item_t        out_data
);

  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;
  mor_pkg::out_item_t slot0_r;
  mor_pkg::out_item_t slot1_r;
  logic               pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign pop       = out_valid && out_ready;
  assign space     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      cnt_nxt = push_res.count;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0_r <= push_res.first;
      slot1_r <= push_res.second;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))
    else $error("push into occupied output buffer");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!slot0_r.last_write && slot1_r.last_write))
    else $error("LUI write not ahead of low write");
`endif

endmodule

`default_nettype wire
